[design/ctok_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ctok_pkg: shared types and constants of the C subset tokenizer
// Holds the lexer mode codes, the character codes and the result record type.
// ----------------------------------------------------------------------------
package ctok_pkg;

    // Lexer modes
    localparam logic [2:0] M_IDLE  = 3'd0;
    localparam logic [2:0] M_WORD  = 3'd1;
    localparam logic [2:0] M_OP    = 3'd2;
    localparam logic [2:0] M_SQ    = 3'd3;
    localparam logic [2:0] M_DQ    = 3'd4;
    localparam logic [2:0] M_SLASH = 3'd5;
    localparam logic [2:0] M_CBODY = 3'd6;
    localparam logic [2:0] M_CSTAR = 3'd7;

    // Character codes
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SQ    = 8'd39;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Result queue geometry
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int Q_CW    = 3;

    typedef struct packed {
        logic [7:0] out_char;
        logic       token_start;
        logic       text_ended;
        logic       unterminated;
        logic       last;
    } t_result;

    function automatic logic is_word(input logic [7:0] c);
        is_word = (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_ZERO && c <= CH_NINE)
                  || (c == CH_UNDER);
    endfunction

    function automatic logic is_op(input logic [7:0] c);
        is_op = (c == CH_LT) || (c == CH_EQ) || (c == CH_GT) || (c == CH_BAR)
                || (c == CH_AMP) || (c == CH_BANG);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        is_space = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF);
    endfunction

endpackage
`default_nettype wire

[design/ctok_lexer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ctok_lexer: one-step tokenizer logic
// From the current mode and one input word, forms up to two results and the
// next mode.
// ----------------------------------------------------------------------------
module ctok_lexer (
    input  wire logic [2:0]       i_mode,
    input  wire logic [7:0]       i_ch,
    input  wire logic             i_eot,
    output logic [1:0]            o_count,
    output ctok_pkg::t_result     o_res0,
    output ctok_pkg::t_result     o_res1,
    output logic [2:0]            o_next_mode
);

    logic               bt_emit;
    logic [2:0]         bt_mode;
    ctok_pkg::t_result  chr_cont;
    ctok_pkg::t_result  chr_start;
    ctok_pkg::t_result  slash_tok;
    ctok_pkg::t_result  r0;
    ctok_pkg::t_result  r1;
    logic [1:0]         cnt;

    // Start of a token: what the byte opens and whether it is kept
    always_comb begin
        bt_emit = 1'b1;
        bt_mode = ctok_pkg::M_IDLE;
        if (ctok_pkg::is_space(i_ch)) begin
            bt_emit = 1'b0;
        end else if (i_ch == ctok_pkg::CH_SLASH) begin
            bt_emit = 1'b0;
            bt_mode = ctok_pkg::M_SLASH;
        end else if (ctok_pkg::is_word(i_ch)) begin
            bt_mode = ctok_pkg::M_WORD;
        end else if (ctok_pkg::is_op(i_ch)) begin
            bt_mode = ctok_pkg::M_OP;
        end else if (i_ch == ctok_pkg::CH_SQ) begin
            bt_mode = ctok_pkg::M_SQ;
        end else if (i_ch == ctok_pkg::CH_DQ) begin
            bt_mode = ctok_pkg::M_DQ;
        end
    end

    assign chr_cont  = '{out_char: i_ch, token_start: 1'b0, text_ended: 1'b0,
                         unterminated: 1'b0, last: 1'b0};
    assign chr_start = '{out_char: i_ch, token_start: 1'b1, text_ended: 1'b0,
                         unterminated: 1'b0, last: 1'b0};
    assign slash_tok = '{out_char: ctok_pkg::CH_SLASH, token_start: 1'b1, text_ended: 1'b0,
                         unterminated: 1'b0, last: 1'b0};

    always_comb begin
        r0          = chr_start;
        r1          = chr_start;
        cnt         = 2'd0;
        o_next_mode = i_mode;
        if (i_eot) begin
            o_next_mode = ctok_pkg::M_IDLE;
            if (i_mode == ctok_pkg::M_SLASH) begin
                r0  = slash_tok;
                r1  = '{out_char: ctok_pkg::CH_NUL, token_start: 1'b0, text_ended: 1'b1,
                        unterminated: 1'b0, last: 1'b0};
                cnt = 2'd2;
            end else begin
                r0  = '{out_char: ctok_pkg::CH_NUL, token_start: 1'b0, text_ended: 1'b1,
                        unterminated: (i_mode == ctok_pkg::M_SQ) || (i_mode == ctok_pkg::M_DQ)
                                      || (i_mode == ctok_pkg::M_CBODY)
                                      || (i_mode == ctok_pkg::M_CSTAR),
                        last: 1'b0};
                cnt = 2'd1;
            end
        end else begin
            unique case (i_mode) inside
                ctok_pkg::M_WORD, ctok_pkg::M_OP: begin
                    if ((i_mode == ctok_pkg::M_WORD) ? ctok_pkg::is_word(i_ch)
                                                     : ctok_pkg::is_op(i_ch)) begin
                        r0  = chr_cont;
                        cnt = 2'd1;
                    end else begin
                        cnt         = {1'b0, bt_emit};
                        o_next_mode = bt_mode;
                    end
                end
                ctok_pkg::M_SQ, ctok_pkg::M_DQ: begin
                    r0  = chr_cont;
                    cnt = 2'd1;
                    if ((i_mode == ctok_pkg::M_SQ && i_ch == ctok_pkg::CH_SQ) ||
                        (i_mode == ctok_pkg::M_DQ && i_ch == ctok_pkg::CH_DQ)) begin
                        o_next_mode = ctok_pkg::M_IDLE;
                    end
                end
                ctok_pkg::M_SLASH: begin
                    if (i_ch == ctok_pkg::CH_STAR) begin
                        o_next_mode = ctok_pkg::M_CSTAR;
                    end else begin
                        // flush the held slash, then handle the byte afresh
                        r0          = slash_tok;
                        cnt         = bt_emit ? 2'd2 : 2'd1;
                        o_next_mode = bt_mode;
                    end
                end
                ctok_pkg::M_CBODY: begin
                    if (i_ch == ctok_pkg::CH_STAR) begin
                        o_next_mode = ctok_pkg::M_CSTAR;
                    end
                end
                ctok_pkg::M_CSTAR: begin
                    if (i_ch == ctok_pkg::CH_SLASH) begin
                        o_next_mode = ctok_pkg::M_IDLE;
                    end else if (i_ch != ctok_pkg::CH_STAR) begin
                        o_next_mode = ctok_pkg::M_CBODY;
                    end
                end
                default: begin
                    cnt         = {1'b0, bt_emit};
                    o_next_mode = bt_mode;
                end
            endcase
        end
        // mark the final result of this word
        if (cnt == 2'd1) begin
            r0.last = 1'b1;
        end
        if (cnt == 2'd2) begin
            r1.last = 1'b1;
        end
    end

    assign o_count = cnt;
    assign o_res0  = r0;
    assign o_res1  = r1;

endmodule
`default_nettype wire

[design/ctok_outq.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ctok_outq: result queue
// Four-entry queue taking up to two results per cycle and giving one.
// ----------------------------------------------------------------------------
module ctok_outq (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [1:0]                    i_push_cnt,
    input  wire ctok_pkg::t_result             i_res0,
    input  wire ctok_pkg::t_result             i_res1,
    input  wire logic                          i_pop,
    output logic [ctok_pkg::Q_CW-1:0]          o_count,
    output ctok_pkg::t_result                  o_head
);

    ctok_pkg::t_result              r_mem [ctok_pkg::Q_DEPTH];
    logic [ctok_pkg::Q_AW-1:0]      r_wr_ptr;
    logic [ctok_pkg::Q_AW-1:0]      r_rd_ptr;
    logic [ctok_pkg::Q_CW-1:0]      r_count;
    logic [ctok_pkg::Q_AW-1:0]      n_wr_ptr;
    logic [ctok_pkg::Q_CW-1:0]      n_count;
    logic                           pop_ok;

    assign pop_ok   = i_pop && (r_count != '0);
    assign n_wr_ptr = r_wr_ptr + ctok_pkg::Q_AW'(i_push_cnt);
    assign n_count  = r_count + ctok_pkg::Q_CW'(i_push_cnt) - ctok_pkg::Q_CW'(pop_ok);

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_res0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[r_wr_ptr + ctok_pkg::Q_AW'(1)] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + ctok_pkg::Q_AW'(1);
            end
        end
    end

    assign o_count = r_count;
    assign o_head  = r_mem[r_rd_ptr];

endmodule
`default_nettype wire

[design/c_subset_tokenizer.sv]
`default_nettype none
// Flow: an accepted word is held in the input register and lexed; its results
//   enter the result queue once it has room, and its head drives the output.
// Throughput: one input word per cycle while not stalled; the result queue
//   drains one result per unstalled cycle, soaking up the flushed-slash pair.
// Reset: synchronous, active low; the lexer returns to between-tokens, the
//   input register and the result queue come up empty.
// ----------------------------------------------------------------------------
// c_subset_tokenizer: streaming tokenizer for a small C subset
// Splits a byte stream into tokens, echoing each kept byte with a
// token-start flag and closing with an end-of-text result.
// ----------------------------------------------------------------------------
module c_subset_tokenizer (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // input channel
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_ch,
    input  wire logic       i_end_of_text,
    // output channel
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_out_char,
    output logic            o_token_start,
    output logic            o_text_ended,
    output logic            o_unterminated,
    output logic            o_last
);

    // Input register: hold one word until the lexer can take it
    logic                         r_in_valid;
    logic [7:0]                   r_ch;
    logic                         r_eot;
    // Lexer mode (between tokens, in a run, in a literal, held slash, comment)
    logic [2:0]                   r_mode;

    logic [1:0]                   lex_count;
    ctok_pkg::t_result            lex_res0;
    ctok_pkg::t_result            lex_res1;
    logic [2:0]                   lex_next_mode;
    logic [ctok_pkg::Q_CW-1:0]    q_count;
    ctok_pkg::t_result            q_head;
    logic                         pop;
    logic                         room;
    logic                         take;
    logic [1:0]                   push_cnt;

    ctok_lexer u_lexer (
        .i_mode      (r_mode),
        .i_ch        (r_ch),
        .i_eot       (r_eot),
        .o_count     (lex_count),
        .o_res0      (lex_res0),
        .o_res1      (lex_res1),
        .o_next_mode (lex_next_mode)
    );

    // Advance the held word only if the queue has room for two results after
    // this cycle's pop; a single flush per word never overruns four entries.
    assign pop  = o_valid && !i_stall;
    assign room = (q_count <= ctok_pkg::Q_CW'(2)) || ((q_count == ctok_pkg::Q_CW'(3)) && pop);
    assign take = r_in_valid && room;
    assign push_cnt = take ? lex_count : 2'd0;

    ctok_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_res0     (lex_res0),
        .i_res1     (lex_res1),
        .i_pop      (pop),
        .o_count    (q_count),
        .o_head     (q_head)
    );

    // Stall the source only while a word is held that cannot advance
    assign o_stall = r_in_valid && !room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= ctok_pkg::M_IDLE;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (take) begin
                r_mode <= lex_next_mode;
            end
        end
    end

    // Payload of the input register: load on accept, hold otherwise
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_ch  <= i_ch;
            r_eot <= i_end_of_text;
        end
    end

    // Drive the output word from the head of the queue
    assign o_valid        = (q_count != '0);
    assign o_out_char     = q_head.out_char;
    assign o_token_start  = q_head.token_start;
    assign o_text_ended   = q_head.text_ended;
    assign o_unterminated = q_head.unterminated;
    assign o_last         = q_head.last;

    // The queue never holds more than its depth
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= ctok_pkg::Q_CW'(ctok_pkg::Q_DEPTH))
        else $error("result queue overrun");

    // End of text always returns the lexer to between tokens
    a_eot_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && r_eot) |=> (r_mode == ctok_pkg::M_IDLE))
        else $error("mode not cleared after end of text");

    // The source is stalled only while a word is held
    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid)
        else $error("stall without held word");

    // The end result is always the final result of its word
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_text_ended) |-> o_last)
        else $error("end result not marked last");

endmodule
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the C subset tokenizer
// Streams directed and random source text into the tokenizer with random
// input gaps and output stalls. A local lexer tracks every accepted word,
// queues the result words it should cause, and the monitor checks each
// result field by field, in order.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 3;
    localparam int TIMEOUT_CYCLES = 800_000;
    localparam int SOURCE_WORDS   = 900;
    localparam int DRAIN_LIMIT    = 20_000;
    localparam int TAIL_CYCLES    = 20;

    // One entry of the source stream; a drain marker holds the sender until
    // every outstanding result word has come back.
    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
        logic       drain;
    } t_src_word;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_valid       = 1'b0;
    logic [7:0] i_ch          = 8'h00;
    logic       i_end_of_text = 1'b0;
    logic       i_stall       = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_out_char;
    logic       o_token_start;
    logic       o_text_ended;
    logic       o_unterminated;
    logic       o_last;

    t_src_word          src_words[$];   // source words not yet offered
    t_src_word          next_word;
    ctok_pkg::t_result  token_words[$]; // result words predicted, not yet seen
    ctok_pkg::t_result  step_words[$];  // result words of the word being lexed
    logic [2:0]         lexer_mode = ctok_pkg::M_IDLE;

    int unsigned words_total    = 0;
    int unsigned words_accepted = 0;
    int unsigned mismatches     = 0;
    int unsigned send_idle      = 0;
    int unsigned send_calm      = 0;
    int unsigned stall_left     = 0;
    int unsigned recv_calm      = 0;

    c_subset_tokenizer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_ch           (i_ch),
        .i_end_of_text  (i_end_of_text),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_char     (o_out_char),
        .o_token_start  (o_token_start),
        .o_text_ended   (o_text_ended),
        .o_unterminated (o_unterminated),
        .o_last         (o_last)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Lexer prediction
    // ------------------------------------------------------------------------

    function automatic logic ident_char(input logic [7:0] c);
        return (c >= ctok_pkg::CH_LC_A && c <= ctok_pkg::CH_LC_Z)
               || (c >= ctok_pkg::CH_ZERO && c <= ctok_pkg::CH_NINE)
               || (c == ctok_pkg::CH_UNDER);
    endfunction

    function automatic logic oper_char(input logic [7:0] c);
        return (c == ctok_pkg::CH_LT) || (c == ctok_pkg::CH_EQ) || (c == ctok_pkg::CH_GT)
               || (c == ctok_pkg::CH_BAR) || (c == ctok_pkg::CH_AMP)
               || (c == ctok_pkg::CH_BANG);
    endfunction

    function automatic void emit_word(input logic [7:0] c, input logic start,
                                      input logic ended, input logic unterm);
        ctok_pkg::t_result r;
        r.out_char     = c;
        r.token_start  = start;
        r.text_ended   = ended;
        r.unterminated = unterm;
        r.last         = 1'b0;
        step_words.push_back(r);
    endfunction

    // Treat c as the possible first byte of a token; return the next mode.
    function automatic logic [2:0] open_token(input logic [7:0] c);
        if (c == ctok_pkg::CH_SPACE || c == ctok_pkg::CH_TAB || c == ctok_pkg::CH_LF)
            return ctok_pkg::M_IDLE;
        if (c == ctok_pkg::CH_SLASH) return ctok_pkg::M_SLASH;   // hold back, a star may follow
        emit_word(c, 1'b1, 1'b0, 1'b0);
        if (ident_char(c)) return ctok_pkg::M_WORD;
        if (oper_char(c)) return ctok_pkg::M_OP;
        if (c == ctok_pkg::CH_SQ) return ctok_pkg::M_SQ;
        if (c == ctok_pkg::CH_DQ) return ctok_pkg::M_DQ;
        return ctok_pkg::M_IDLE;
    endfunction

    // Advance the local lexer by one accepted word and queue its results.
    function automatic void tokenize_step(input logic [7:0] c, input logic eot);
        logic [2:0] m;
        int         n;
        m = lexer_mode;
        step_words.delete();
        if (eot) begin
            // flush a held slash ahead of the end marker
            if (m == ctok_pkg::M_SLASH) emit_word(ctok_pkg::CH_SLASH, 1'b1, 1'b0, 1'b0);
            emit_word(ctok_pkg::CH_NUL, 1'b0, 1'b1,
                      (m == ctok_pkg::M_SQ) || (m == ctok_pkg::M_DQ)
                      || (m == ctok_pkg::M_CBODY) || (m == ctok_pkg::M_CSTAR));
            m = ctok_pkg::M_IDLE;
        end else begin
            case (m)
                ctok_pkg::M_WORD: begin
                    if (ident_char(c)) emit_word(c, 1'b0, 1'b0, 1'b0);
                    else m = open_token(c);
                end
                ctok_pkg::M_OP: begin
                    if (oper_char(c)) emit_word(c, 1'b0, 1'b0, 1'b0);
                    else m = open_token(c);
                end
                ctok_pkg::M_SQ: begin
                    emit_word(c, 1'b0, 1'b0, 1'b0);
                    if (c == ctok_pkg::CH_SQ) m = ctok_pkg::M_IDLE;
                end
                ctok_pkg::M_DQ: begin
                    emit_word(c, 1'b0, 1'b0, 1'b0);
                    if (c == ctok_pkg::CH_DQ) m = ctok_pkg::M_IDLE;
                end
                ctok_pkg::M_SLASH: begin
                    if (c == ctok_pkg::CH_STAR) begin
                        m = ctok_pkg::M_CSTAR;
                    end else begin
                        // slash was a token after all; then lex c normally
                        emit_word(ctok_pkg::CH_SLASH, 1'b1, 1'b0, 1'b0);
                        m = open_token(c);
                    end
                end
                ctok_pkg::M_CBODY: begin
                    if (c == ctok_pkg::CH_STAR) m = ctok_pkg::M_CSTAR;
                end
                ctok_pkg::M_CSTAR: begin
                    // a slash right after any star closes, even the opening one
                    if (c == ctok_pkg::CH_SLASH) m = ctok_pkg::M_IDLE;
                    else if (c != ctok_pkg::CH_STAR) m = ctok_pkg::M_CBODY;
                end
                default: begin
                    m = open_token(c);
                end
            endcase
        end
        lexer_mode = m;
        n = step_words.size();
        if (n > 0) step_words[n - 1].last = 1'b1;
        foreach (step_words[k]) token_words.push_back(step_words[k]);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    function automatic void push_ch(input logic [7:0] c);
        t_src_word w;
        w.ch    = c;
        w.eot   = 1'b0;
        w.drain = 1'b0;
        src_words.push_back(w);
        words_total++;
    endfunction

    function automatic void push_eot();
        t_src_word w;
        w.ch    = 8'($urandom_range(0, 255));   // ignored by the block
        w.eot   = 1'b1;
        w.drain = 1'b0;
        src_words.push_back(w);
        words_total++;
    endfunction

    function automatic void push_drain();
        t_src_word w;
        w.ch    = 8'h00;
        w.eot   = 1'b0;
        w.drain = 1'b1;
        src_words.push_back(w);
    endfunction

    function automatic logic [7:0] rand_ident();
        int unsigned r;
        r = $urandom_range(0, 36);
        if (r < 26) return ctok_pkg::CH_LC_A + 8'(r);
        if (r < 36) return ctok_pkg::CH_ZERO + 8'(r - 26);
        return ctok_pkg::CH_UNDER;
    endfunction

    function automatic logic [7:0] rand_oper();
        case ($urandom_range(0, 5))
            0: return ctok_pkg::CH_LT;
            1: return ctok_pkg::CH_EQ;
            2: return ctok_pkg::CH_GT;
            3: return ctok_pkg::CH_BAR;
            4: return ctok_pkg::CH_AMP;
            default: return ctok_pkg::CH_BANG;
        endcase
    endfunction

    // Comment bodies lean on stars and slashes to hit the closing logic.
    function automatic logic [7:0] rand_comment_byte();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 25) return ctok_pkg::CH_STAR;
        if (r < 35) return ctok_pkg::CH_SLASH;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] rand_quoted(input logic [7:0] q);
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        if (c == q) c = ctok_pkg::CH_LC_A;
        return c;
    endfunction

    // Append one snippet of source text.
    function automatic void add_snippet();
        int unsigned kind;
        int unsigned len;
        logic [7:0]  q;
        kind = $urandom_range(0, 99);
        if (kind < 28) begin
            len = $urandom_range(1, 8);
            repeat (len) push_ch(rand_ident());
            return;
        end
        if (kind < 40) begin
            len = $urandom_range(1, 4);
            repeat (len) push_ch(rand_oper());
            return;
        end
        if (kind < 52) begin
            q = $urandom_range(0, 1) ? ctok_pkg::CH_SQ : ctok_pkg::CH_DQ;
            len = $urandom_range(0, 6);
            push_ch(q);
            repeat (len) push_ch(rand_quoted(q));
            push_ch(q);
            return;
        end
        if (kind < 64) begin
            push_ch(ctok_pkg::CH_SLASH);
            push_ch(ctok_pkg::CH_STAR);
            if ($urandom_range(0, 4) == 0) begin
                push_ch(ctok_pkg::CH_SLASH);   // closes at once
                return;
            end
            repeat ($urandom_range(0, 6)) push_ch(rand_comment_byte());
            push_ch(ctok_pkg::CH_STAR);
            push_ch(ctok_pkg::CH_SLASH);
            return;
        end
        if (kind < 70) begin
            push_ch(ctok_pkg::CH_SLASH);
            return;
        end
        if (kind < 84) begin
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(0, 2))
                    0: push_ch(ctok_pkg::CH_SPACE);
                    1: push_ch(ctok_pkg::CH_TAB);
                    default: push_ch(ctok_pkg::CH_LF);
                endcase
            end
            return;
        end
        if (kind < 95) begin
            push_ch(8'($urandom_range(0, 255)));
            return;
        end
        if (kind < 98) begin
            // broken text: end inside a literal or a comment
            case ($urandom_range(0, 2))
                0: push_ch(ctok_pkg::CH_SQ);
                1: push_ch(ctok_pkg::CH_DQ);
                default: begin
                    push_ch(ctok_pkg::CH_SLASH);
                    push_ch(ctok_pkg::CH_STAR);
                end
            endcase
            repeat ($urandom_range(0, 3)) push_ch(rand_comment_byte());
            push_eot();
            return;
        end
        push_eot();
    endfunction

    function automatic void load_directed();
        // word run over the range ends of each class
        push_ch(ctok_pkg::CH_LC_A);
        push_ch(ctok_pkg::CH_LC_Z);
        push_ch(ctok_pkg::CH_ZERO);
        push_ch(ctok_pkg::CH_NINE);
        push_ch(ctok_pkg::CH_UNDER);
        // operator run, broken by the lowest and highest bytes
        push_ch(ctok_pkg::CH_LT);
        push_ch(ctok_pkg::CH_BANG);
        push_ch(ctok_pkg::CH_NUL);
        push_ch(8'hFF);
        // whitespace is dropped
        push_ch(ctok_pkg::CH_SPACE);
        push_ch(ctok_pkg::CH_TAB);
        push_ch(ctok_pkg::CH_LF);
        // held slash flushed by a letter: two results from one word
        push_ch(ctok_pkg::CH_SLASH);
        push_ch(ctok_pkg::CH_LC_A);
        // comment closed by the slash right after its opening star
        push_ch(ctok_pkg::CH_SLASH);
        push_ch(ctok_pkg::CH_STAR);
        push_ch(ctok_pkg::CH_SLASH);
        // comment closed after a run of stars
        push_ch(ctok_pkg::CH_SLASH);
        push_ch(ctok_pkg::CH_STAR);
        push_ch(ctok_pkg::CH_LC_Z);
        push_ch(ctok_pkg::CH_STAR);
        push_ch(ctok_pkg::CH_STAR);
        push_ch(ctok_pkg::CH_SLASH);
        // text ends inside a double-quoted literal
        push_ch(ctok_pkg::CH_DQ);
        push_ch(ctok_pkg::CH_SQ);
        push_eot();
        // text ends on a held slash
        push_ch(ctok_pkg::CH_SLASH);
        push_eot();
        push_drain();
    endfunction

    // Fill up to about SOURCE_WORDS source words, draining now and then.
    function automatic void load_random();
        int unsigned next_drain;
        next_drain = words_total + 300;
        while (words_total < SOURCE_WORDS) begin
            add_snippet();
            if (words_total >= next_drain) begin
                push_drain();
                next_drain += 300;
            end
        end
        push_eot();
    endfunction

    // Mostly short gaps, a few long ones, and now and then a calm stretch.
    function automatic int unsigned pick_gap(inout int unsigned calm);
        int unsigned r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(30, 120);
            return 0;
        end
        if (r < 58) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    // ------------------------------------------------------------------------
    // Driver: offer source words, predict on each accepted word
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                tokenize_step(i_ch, i_end_of_text);
                words_accepted++;
            end
            // the channel is free: pick what to offer next
            if (!i_valid || !o_stall) begin
                if (send_idle > 0) begin
                    i_valid   <= 1'b0;
                    send_idle <= send_idle - 1;
                end else if (src_words.size() > 0 && src_words[0].drain) begin
                    // hold until every predicted result word has come back
                    i_valid <= 1'b0;
                    if (token_words.size() == 0) src_words.delete(0);
                end else if (src_words.size() > 0) begin
                    next_word = src_words.pop_front();
                    i_valid       <= 1'b1;
                    i_ch          <= next_word.ch;
                    i_end_of_text <= next_word.eot;
                    send_idle     <= pick_gap(send_calm);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: stall at random, check every accepted result word
    // ------------------------------------------------------------------------
    task automatic check_result();
        ctok_pkg::t_result want;
        if (token_words.size() == 0) begin
            $error("result word with none expected: out_char %h text_ended %b",
                   o_out_char, o_text_ended);
            mismatches++;
            return;
        end
        want = token_words.pop_front();
        if (o_out_char !== want.out_char) begin
            $error("out_char: expected %h, actual %h", want.out_char, o_out_char);
            mismatches++;
        end
        if (o_token_start !== want.token_start) begin
            $error("token_start: expected %b, actual %b", want.token_start, o_token_start);
            mismatches++;
        end
        if (o_text_ended !== want.text_ended) begin
            $error("text_ended: expected %b, actual %b", want.text_ended, o_text_ended);
            mismatches++;
        end
        if (o_unterminated !== want.unterminated) begin
            $error("unterminated: expected %b, actual %b",
                   want.unterminated, o_unterminated);
            mismatches++;
        end
        if (o_last !== want.last) begin
            $error("last: expected %b, actual %b", want.last, o_last);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) check_result();
            if (stall_left > 0) begin
                i_stall    <= 1'b1;
                stall_left <= stall_left - 1;
            end else begin
                i_stall    <= 1'b0;
                stall_left <= pick_gap(recv_calm);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: reset, run the stream, drain, report
    // ------------------------------------------------------------------------
    initial begin
        int unsigned waited;
        load_directed();
        load_random();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // wait for the last source word to be taken
        while (words_accepted < words_total) @(posedge i_clk);
        waited = 0;
        while (token_words.size() > 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        // let any stray result words show up
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (token_words.size() > 0) begin
            $error("%0d predicted result words never came", token_words.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(2 * CLK_HALF * TIMEOUT_CYCLES);
        $display("Test completed with failures");
        $finish;
    end

endmodule
